FILE: rtl/core/lzwf_pkg.sv
// Shared constants, types and the slot hash of the fixed-width LZW compressor.
`default_nettype none

package lzwf_pkg;

   localparam int CODE_BITS  = 16;
   localparam int HASH_SLOTS = 65536;
   localparam int HASH_BITS  = $clog2(HASH_SLOTS);
   localparam int EPOCH_BITS = 8;
   localparam int BYTE_BITS  = 8;
   localparam int FIRST_CODE = 256;

   // Packer holds fewer than one byte of old bits plus one whole code.
   localparam int PACK_W     = CODE_BITS + BYTE_BITS - 1;
   localparam int PACK_CNT_W = $clog2(PACK_W + 1);

   localparam int FOLD_N = (CODE_BITS + BYTE_BITS + HASH_BITS - 1) / HASH_BITS;
   localparam int FOLD_W = FOLD_N * HASH_BITS;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [HASH_BITS-1:0] slot_type;

   localparam logic [HASH_BITS:0] SLOT_COUNT = (HASH_BITS + 1)'(HASH_SLOTS);
   localparam slot_type           LAST_SLOT  = slot_type'(HASH_SLOTS - 1);

   typedef struct packed {
      logic [EPOCH_BITS-1:0] tag;
      code_type              pre;
      logic [BYTE_BITS-1:0]  ch;
      code_type              code;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic     valid;
      logic     last;
      code_type code;
   } code_req_type;

   // Folds the (prefix, byte) key down to a slot index below HASH_SLOTS.
   function automatic slot_type slot_hash(input code_type pre, input logic [BYTE_BITS-1:0] ch);
      logic [FOLD_W-1:0]    key;
      logic [HASH_BITS-1:0] h;
      logic [HASH_BITS:0]   wide;
      key = FOLD_W'({pre, ch});
      h = slot_type'(ch) << (HASH_BITS - BYTE_BITS);
      for (int i = 0; i < FOLD_N; i++) begin
         h = h ^ key[i*HASH_BITS +: HASH_BITS];
      end
      wide = {1'b0, h};
      if (wide >= SLOT_COUNT) begin
         wide = wide - SLOT_COUNT;
      end
      return wide[HASH_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lzwf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lzwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lzwf_dict_ctrl.sv
// Dictionary sequencer: hashed lookup with linear probing, insert and code hand-off.
`default_nettype none

module lzwf_dict_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_in_byte,
   input  wire logic                          req_in_last,
   output logic                               rd_en,
   output lzwf_pkg::slot_type                 rd_addr,
   input  wire logic [lzwf_pkg::ENTRY_W-1:0]  rd_data,
   output logic                               wr_en,
   output lzwf_pkg::slot_type                 wr_addr,
   output logic      [lzwf_pkg::ENTRY_W-1:0]  wr_data,
   output lzwf_pkg::code_req_type             code_req,
   input  wire logic                          code_ready
);

   import lzwf_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_MISS   = 3'd3;
   localparam logic [2:0] ST_FINAL  = 3'd4;

   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

   logic [2:0]            state_ff, state_in;
   code_type              prefix_ff, prefix_in;
   logic                  prefix_valid_ff, prefix_valid_in;
   logic [CODE_BITS:0]    next_free_ff, next_free_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   slot_type              probe_ff, probe_in;
   logic [HASH_BITS:0]    probe_cnt_ff, probe_cnt_in;
   logic                  free_found_ff, free_found_in;
   logic [BYTE_BITS-1:0]  ch_ff, ch_in;
   logic                  last_ff, last_in;

   entry_type rd_entry;
   entry_type wr_entry;
   slot_type  probe_next;

   assign rd_entry   = entry_type'(rd_data);
   assign probe_next = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign wr_data    = ENTRY_W'(wr_entry);

   always_comb begin
      state_in        = state_ff;
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      next_free_in    = next_free_ff;
      epoch_in        = epoch_ff;
      probe_in        = probe_ff;
      probe_cnt_in    = probe_cnt_ff;
      free_found_in   = free_found_ff;
      ch_in           = ch_ff;
      last_in         = last_ff;
      rd_en           = 1'b0;
      rd_addr         = probe_ff;
      wr_en           = 1'b0;
      wr_addr         = probe_ff;
      wr_entry        = '{tag: epoch_ff, pre: prefix_ff, ch: ch_ff,
                          code: next_free_ff[CODE_BITS-1:0]};
      code_req        = '{valid: 1'b0, last: 1'b0, code: prefix_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            // Tag zero never matches a live epoch, so every slot reads as empty.
            wr_en    = 1'b1;
            wr_entry = '0;
            if (probe_ff == LAST_SLOT) begin
               probe_in = '0;
               epoch_in = EPOCH_FIRST;
               state_in = ST_IDLE;
            end else begin
               probe_in = probe_next;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ch_in   = req_in_byte;
               last_in = req_in_last;
               if (!prefix_valid_ff) begin
                  prefix_in       = code_type'(req_in_byte);
                  prefix_valid_in = 1'b1;
                  state_in        = req_in_last ? ST_FINAL : ST_IDLE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = slot_hash(prefix_ff, req_in_byte);
                  probe_in     = rd_addr;
                  probe_cnt_in = (HASH_BITS + 1)'(1);
                  state_in     = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (rd_entry.tag != epoch_ff) begin
               free_found_in = 1'b1;
               state_in      = ST_MISS;
            end else if (rd_entry.pre == prefix_ff && rd_entry.ch == ch_ff) begin
               prefix_in = rd_entry.code;
               state_in  = last_ff ? ST_FINAL : ST_IDLE;
            end else if (probe_cnt_ff == SLOT_COUNT) begin
               free_found_in = 1'b0;
               state_in      = ST_MISS;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = probe_next;
               probe_in     = probe_next;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end
         ST_MISS: begin
            code_req.valid = 1'b1;
            if (code_ready) begin
               if (free_found_ff && !next_free_ff[CODE_BITS]) begin
                  wr_en        = 1'b1;
                  next_free_in = next_free_ff + 1'b1;
               end
               prefix_in = code_type'(ch_ff);
               state_in  = last_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            code_req.valid = 1'b1;
            code_req.last  = 1'b1;
            if (code_ready) begin
               prefix_in       = '0;
               prefix_valid_in = 1'b0;
               next_free_in    = (CODE_BITS + 1)'(FIRST_CODE);
               if (epoch_ff == '1) begin
                  probe_in = '0;
                  state_in = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            probe_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         next_free_ff    <= (CODE_BITS + 1)'(FIRST_CODE);
         epoch_ff        <= EPOCH_FIRST;
         probe_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         prefix_ff       <= prefix_in;
         prefix_valid_ff <= prefix_valid_in;
         next_free_ff    <= next_free_in;
         epoch_ff        <= epoch_in;
         probe_ff        <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_cnt_ff  <= probe_cnt_in;
      free_found_ff <= free_found_in;
      ch_ff         <= ch_in;
      last_ff       <= last_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/lzwf_packer.sv
// Bit packer: takes codes, emits bytes MSB first through a registered output, pads on flush.
`default_nettype none

module lzwf_packer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lzwf_pkg::code_req_type  code_req,
   output logic                         code_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_last
);

   import lzwf_pkg::*;

   localparam logic [PACK_CNT_W-1:0] CNT_BYTE  = PACK_CNT_W'(BYTE_BITS);
   localparam logic [PACK_CNT_W-1:0] CNT_CODE  = PACK_CNT_W'(CODE_BITS);
   localparam logic [PACK_CNT_W-1:0] CNT_ALIGN = PACK_CNT_W'(PACK_W - CODE_BITS);

   logic [PACK_W-1:0]     buf_ff, buf_in;
   logic [PACK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  flush_ff, flush_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;

   logic out_free;
   logic emit;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign code_ready = (cnt_ff < CNT_BYTE) && !flush_ff;
   assign emit       = out_free && (flush_ff ? (cnt_ff != '0) : (cnt_ff >= CNT_BYTE));

   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = buf_ff[PACK_W-1 -: 8];
         buf_in       = buf_ff << BYTE_BITS;
         cnt_in       = (cnt_ff > CNT_BYTE) ? cnt_ff - CNT_BYTE : '0;
         out_last_in  = flush_ff && (cnt_in == '0);
         if (flush_ff && cnt_in == '0) begin
            flush_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end

      // Pending bits sit at the top; the new code lands right below them.
      if (code_req.valid && code_ready) begin
         buf_in   = buf_ff | (PACK_W'(code_req.code) << (CNT_ALIGN - cnt_ff));
         cnt_in   = cnt_ff + CNT_CODE;
         flush_in = code_req.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lzw_fixed_width_compressor_top.sv
// Top level of the LZW compressor with fixed-width codes and a hashed dictionary.
// Extending the string takes the accept and one read; ending it adds one read per extra probe
// and the code hand-off; a stream's first byte is only accepted, a last byte adds the final code.
// A code's bytes pass the packing buffer and the output register, one byte per cycle while not
// stalled; the packer takes the next code once under 8 bits are pending, so it can hold codes up.
// Reset: synchronous, active high, then a clearing pass; it reruns every 255 streams.
`default_nettype none

module lzw_fixed_width_compressor_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   import lzwf_pkg::*;

   // The dictionary lives in one RAM. Each entry carries an epoch tag; an entry
   // whose tag differs from the current epoch counts as an empty slot. Ending a
   // stream bumps the epoch, which empties the dictionary; after the last epoch
   // the clearing pass writes tag zero instead, which never matches a live epoch.
   logic               ram_rd_en;
   slot_type           ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_wr_en;
   slot_type           ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;

   // Codes travel from the sequencer to the packer one transaction at a time.
   code_req_type code_req;
   logic         code_ready;

   lzwf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HASH_SLOTS)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The sequencer accepts one input transaction at a time and walks the probe
   // chain one slot per cycle. An insert is written in the same cycle the
   // emitted code is taken, so the next lookup always sees it.
   lzwf_dict_ctrl u_dict_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .rd_en       (ram_rd_en),
      .rd_addr     (ram_rd_addr),
      .rd_data     (ram_rd_data),
      .wr_en       (ram_wr_en),
      .wr_addr     (ram_wr_addr),
      .wr_data     (ram_wr_data),
      .code_req    (code_req),
      .code_ready  (code_ready)
   );

   // The packer owns the output register, so input bytes that extend the string
   // are still taken while a result transaction is stalled.
   lzwf_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .code_req     (code_req),
      .code_ready   (code_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

FILE: rtl/core/lzwf_checker.sv
// Port-level checker for the LZW compressor top level, with its bind statement.
`default_nettype none

module lzwf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       req_in_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled result transaction changed");

   // The clearing pass keeps the input stalled right after reset.
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not stalled during clearing pass");

   // Reset empties the output register.
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input stays stalled right after the final byte of a stream is accepted.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_last |=> req_stall)
      else $error("input accepted right after a last transaction");

endmodule

bind lzw_fixed_width_compressor_top lzwf_checker u_lzwf_checker (.*);

`default_nettype wire

FILE: dv/lzw_code_stream_checker.sv
// Watches both channels of the LZW compressor, predicts its packed code bytes and compares them.
`timescale 1ns / 1ps

module lzw_code_stream_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_out_last,
   output int              fail_count,
   output int              pending_count,
   output int              checked_count
);

   import lzwf_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } code_byte_type;

   localparam int CODE_SPACE = 1 << CODE_BITS;

   // Predicted compressor state: current string, code counter, bit packer and the
   // string table, kept as an exact map since the hash only decides slot placement.
   code_type      cur_code;
   logic          cur_open;
   int            next_code;
   logic [31:0]   pack_buf;
   int            pack_bits;
   code_type      string_table [logic [CODE_BITS+7:0]];
   code_byte_type expected_bytes [$];
   int            errors = 0;
   int            checked = 0;

   task automatic restart_stream();
      cur_code  = '0;
      cur_open  = 1'b0;
      next_code = FIRST_CODE;
      pack_buf  = '0;
      pack_bits = 0;
      string_table.delete();
   endtask

   // Appends one code to the packer, MSB first, and releases every whole byte.
   task automatic pack_code(input code_type c);
      pack_buf  = pack_buf | (32'(c) << (32 - CODE_BITS - pack_bits));
      pack_bits = pack_bits + CODE_BITS;
      while (pack_bits >= 8) begin
         expected_bytes.push_back('{data: pack_buf[31:24], last: 1'b0});
         pack_buf  = pack_buf << 8;
         pack_bits = pack_bits - 8;
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic last);
      logic [CODE_BITS+7:0] key;
      code_byte_type        tail;
      key = {cur_code, b};
      if (!cur_open) begin
         cur_code = code_type'(b);
         cur_open = 1'b1;
      end else if (string_table.exists(key)) begin
         cur_code = string_table[key];
      end else begin
         pack_code(cur_code);
         // The table stops growing once the code space is used up.
         if (next_code < CODE_SPACE) begin
            string_table[key] = code_type'(next_code);
            next_code = next_code + 1;
         end
         cur_code = code_type'(b);
      end
      if (last) begin
         pack_code(cur_code);
         if (pack_bits > 0) begin
            expected_bytes.push_back('{data: pack_buf[31:24], last: 1'b0});
         end
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
         restart_stream();
      end
   endtask

   always @(posedge clock) begin
      code_byte_type want;
      if (reset) begin
         restart_stream();
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_in_byte, req_in_last);
         end
         if (rsp_valid && !rsp_stall) begin
            checked = checked + 1;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, got byte %02h last %0b",
                        $time, rsp_out_byte, rsp_out_last);
               errors = errors + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %02h, got %02h",
                           $time, want.data, rsp_out_byte);
                  errors = errors + 1;
               end
               if (rsp_out_last !== want.last) begin
                  $display("%0t: out_last mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_out_last);
                  errors = errors + 1;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_bytes.size();
      checked_count <= checked;
   end

endmodule

FILE: dv/tb_lzw_fixed_width_compressor_top.sv
// Stimulus and verdict for the fixed-width LZW compressor, checked by a scoreboard module.
`timescale 1ns / 1ps

module tb_lzw_fixed_width_compressor_top;

   // Kinds of stream content. Narrow alphabets and repeated motifs make the
   // string table hit often, so long strings and high codes get exercised;
   // noise streams mostly miss and emit a code per byte.
   typedef enum int {
      CONTENT_NARROW,
      CONTENT_MOTIF,
      CONTENT_NOISE
   } content_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   int fail_count;
   int pending_count;
   int checked_count;

   // Percent chance that a side starts an idle burst, per cycle on the result side
   // and per byte on the input side; zero gives stretches with no idling at all.
   int idle_rate = 0;
   int stall_left = 0;
   int items_sent = 0;
   int streams_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lzw_fixed_width_compressor_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   lzw_code_stream_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // The result side stalls in random bursts. The stall value is worked out first
   // so that rsp_stall gets exactly one assignment per edge.
   always @(negedge clock) begin
      logic hold;
      hold = 1'b0;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         hold = 1'b1;
      end else if (!reset && idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
         stall_left = $urandom_range(1, 6) - 1;
         hold = 1'b1;
      end
      rsp_stall <= hold;
   end

   // Offers one byte and returns at the rising edge that accepts it. An idle
   // burst may come first; during it the payload carries junk, which the block
   // must ignore because valid is low. Valid stays high between back-to-back
   // transactions, so it is never lowered and raised in the same step.
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         req_in_last <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   // Sends a fixed byte sequence as one whole stream; the final byte is marked last.
   task automatic send_fixed_stream(input logic [7:0] data [$]);
      for (int i = 0; i < data.size(); i++) begin
         send_item(data[i], i == data.size() - 1);
      end
      streams_sent = streams_sent + 1;
   endtask

   // Builds a random stream of the given length and content kind.
   task automatic send_random_stream(input int len, input content_kind_type kind);
      logic [7:0] base;
      logic [7:0] motif [8];
      logic [7:0] b;
      int         span;
      int         motif_len;
      base      = 8'($urandom);
      span      = $urandom_range(1, 4);
      motif_len = $urandom_range(2, 8);
      for (int i = 0; i < 8; i++) begin
         motif[i] = 8'($urandom);
      end
      for (int i = 0; i < len; i++) begin
         case (kind)
            CONTENT_NARROW: begin
               b = base + 8'($urandom_range(0, span - 1));
            end
            CONTENT_MOTIF: begin
               b = motif[i % motif_len];
            end
            default: begin
               b = 8'($urandom);
            end
         endcase
         send_item(b, i == len - 1);
      end
      streams_sent = streams_sent + 1;
   endtask

   // Picks a stream length and kind for the random phases. Most streams are
   // short; now and then a long one lets strings and codes grow further.
   task automatic send_any_stream();
      int               len;
      int               pick;
      content_kind_type kind;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(40, 80);
      end else begin
         len = $urandom_range(1, 16);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         kind = CONTENT_NARROW;
      end else if (pick < 80) begin
         kind = CONTENT_MOTIF;
      end else begin
         kind = CONTENT_NOISE;
      end
      send_random_stream(len, kind);
   endtask

   function automatic int random_idle_rate();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 30;
      endcase
   endfunction

   initial begin
      int target;
      // Synchronous reset comes first. The block then runs its table-clearing
      // pass with req_stall high; send_item simply waits it out.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed streams: a lone zero byte and a lone 0xFF byte (single-byte
      // streams with the extreme codes), a run of one repeated byte so that
      // each new string extends the previous one, and an alternating 00/FF
      // stream sent twice to show the table is emptied at each end of stream.
      idle_rate = 20;
      send_fixed_stream('{8'h00});
      send_fixed_stream('{8'hFF});
      send_fixed_stream('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
      send_fixed_stream('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
      send_fixed_stream('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});

      // First random phase: mixed streams with varying idle pressure.
      while (items_sent < 80) begin
         idle_rate = random_idle_rate();
         send_any_stream();
      end

      // Push the stream count past 255 with single-byte streams so the block's
      // periodic clearing pass runs, and later streams must not see stale entries.
      while (streams_sent < 262) begin
         idle_rate = random_idle_rate();
         send_fixed_stream('{8'($urandom)});
      end

      // Second random phase after the clearing pass. The closing stretch runs
      // with no idling on either side.
      target = items_sent + 70;
      while (items_sent < target) begin
         if (items_sent > target - 30) begin
            idle_rate = 0;
         end else begin
            idle_rate = random_idle_rate();
         end
         send_any_stream();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain every expected byte, then allow extra cycles so that any
      // spurious trailing transaction would still be caught.
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);

      $display("Sent %0d input bytes in %0d streams, including single-byte, repetitive",
               items_sent, streams_sent);
      $display("and noisy streams across a table-clearing pass; %0d output bytes checked.",
               checked_count);
      if (fail_count == 0) begin
         $display("tb_lzw_fixed_width_compressor_top passed");
      end else begin
         $display("tb_lzw_fixed_width_compressor_top failed");
      end
      $finish;
   end

   // Watchdog: two clearing passes plus a few hundred streams under heavy
   // stalling finish well before this timeout.
   initial begin
      #40000000;
      $display("tb_lzw_fixed_width_compressor_top failed");
      $finish;
   end

endmodule
